/* rtl/core/isbn_pkg.sv */
// ----------------------------------------------------------------------------
// isbn_pkg: shared types and constants for the ISBN check-digit validator
// Transaction payloads, the classified item carried between front and back,
// and the length codes of the verdict.
// ----------------------------------------------------------------------------
package isbn_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       end_of_string;
    } isbn_in_t;

    // Result transaction payload
    typedef struct packed {
        logic       valid_res;
        logic [1:0] length_kind;
    } isbn_out_t;

    // Character after classification by the front end
    typedef struct packed {
        logic [3:0] digit_val;   // 0 when not a digit
        logic       is_digit;
        logic       is_x;
        logic       has_char;
        logic       end_of_string;
    } isbn_item_t;

    // Verdict length codes
    localparam logic [1:0] LEN_OTHER    = 2'd0;
    localparam logic [1:0] LEN_TEN      = 2'd1;
    localparam logic [1:0] LEN_THIRTEEN = 2'd2;

    // Character positions and limits
    localparam logic [3:0] POS_TENTH     = 4'd9;
    localparam logic [3:0] COUNT_TEN     = 4'd10;
    localparam logic [3:0] COUNT_THIRTEEN = 4'd13;
    localparam logic [3:0] COUNT_SAT     = 4'd14;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_UPPER_X = 8'h58;

endpackage

/* rtl/core/isbn_front.sv */
// ----------------------------------------------------------------------------
// isbn_front: input classifier
// Accepts input transactions and classifies each character as digit, 'X'
// or other before it enters the queue.
// ----------------------------------------------------------------------------
module isbn_front import isbn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  isbn_in_t   s_data,
    input  logic       q_full,
    output logic       q_push,
    output isbn_item_t q_item
);

    logic accept_reg;
    logic accept_next;

    // Take a transaction whenever the queue has room
    assign s_ready = ~q_full;
    assign q_push  = s_valid & ~q_full;

    // Character classification
    always_comb begin
        q_item.is_digit      = (s_data.ch >= ASCII_ZERO) && (s_data.ch <= ASCII_NINE);
        q_item.digit_val     = q_item.is_digit ? 4'(s_data.ch - ASCII_ZERO) : 4'd0;
        q_item.is_x          = (s_data.ch == ASCII_UPPER_X);
        q_item.has_char      = s_data.has_char;
        q_item.end_of_string = s_data.end_of_string;
    end

    // Transaction seen last cycle
    assign accept_next = q_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_reg <= 1'b0;
        end else begin
            accept_reg <= accept_next;
        end
    end

    // The queue is not full when reset is released, as reset leaves it empty
    a_no_full_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !q_full)
        else $error("queue full straight after reset");

    // A push only happens with valid input and room in the queue
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_reg |-> $past(s_valid) && !$past(q_full))
        else $error("push without room");

    // Classification is exclusive
    a_digit_not_x: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !(q_item.is_digit && q_item.is_x))
        else $error("character both digit and X");

endmodule

/* rtl/core/isbn_queue.sv */
// ----------------------------------------------------------------------------
// isbn_queue: two-entry queue between front and back
// Lets the classifier and the accumulator stall independently.
// ----------------------------------------------------------------------------
module isbn_queue import isbn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  isbn_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output isbn_item_t pop_item
);

    isbn_item_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

endmodule

/* rtl/core/isbn_back.sv */
// ----------------------------------------------------------------------------
// isbn_back: checksum accumulator and verdict register
// Updates the running ISBN-10 and ISBN-13 sums per character and registers
// the verdict on the end marker.
// ----------------------------------------------------------------------------
module isbn_back import isbn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  isbn_item_t q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output isbn_out_t  m_data
);

    logic [3:0] char_count_reg,  char_count_next;
    logic [3:0] sum11_reg,       sum11_next;
    logic [3:0] sum10_reg,       sum10_next;
    logic       nine_ok_reg,     nine_ok_next;
    logic       tenth_ok_reg,    tenth_ok_next;
    logic       tail_ok_reg,     tail_ok_next;
    logic       m_valid_reg,     m_valid_next;
    isbn_out_t  m_data_reg,      m_data_next;

    logic       out_room;
    logic       take;
    logic [3:0] pos;
    logic [7:0] p11;
    logic [15:0] q11_full;
    logic [3:0] q11;
    logic [7:0] r11;
    logic [4:0] s11;
    logic [4:0] t10;
    logic [5:0] s10;

    assign out_room = ~m_valid_reg | m_ready;
    // Items without an end marker never need the output register
    assign q_pop    = q_not_empty & (~q_item.end_of_string | out_room);
    assign pos      = char_count_reg;
    assign take     = q_pop & q_item.has_char & (pos < COUNT_SAT);

    // Weighted ISBN-10 term, reduced modulo 11 by reciprocal multiply
    always_comb begin
        if (pos < POS_TENTH) begin
            p11 = {4'd0, q_item.digit_val} * {4'd0, 4'd10 - pos};
        end else if (pos == POS_TENTH) begin
            p11 = q_item.is_digit ? {4'd0, q_item.digit_val} :
                  (q_item.is_x ? 8'd10 : 8'd0);
        end else begin
            p11 = 8'd0;
        end
        q11_full = {8'd0, p11} * 16'd187;
        q11      = {1'b0, q11_full[13:11]} | {q11_full[14], 3'd0};
        r11      = p11 - {4'd0, q11} * 8'd11;
        s11      = {1'b0, sum11_reg} + r11[4:0];
        if (s11 >= 5'd11) begin
            s11 = s11 - 5'd11;
        end
    end

    // Weighted ISBN-13 term, reduced modulo 10
    always_comb begin
        t10 = pos[0] ? {1'b0, q_item.digit_val} * 5'd3 : {1'b0, q_item.digit_val};
        s10 = {2'd0, sum10_reg} + {1'b0, t10};
        if (s10 >= 6'd30) begin
            s10 = s10 - 6'd30;
        end else if (s10 >= 6'd20) begin
            s10 = s10 - 6'd20;
        end else if (s10 >= 6'd10) begin
            s10 = s10 - 6'd10;
        end
    end

    // State update and verdict
    always_comb begin
        char_count_next = char_count_reg;
        sum11_next      = sum11_reg;
        sum10_next      = sum10_reg;
        nine_ok_next    = nine_ok_reg;
        tenth_ok_next   = tenth_ok_reg;
        tail_ok_next    = tail_ok_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_data_next     = m_data_reg;

        if (take) begin
            char_count_next = pos + 4'd1;
            sum11_next      = s11[3:0];
            sum10_next      = s10[3:0];
            if (pos < POS_TENTH) begin
                if (!q_item.is_digit) begin
                    nine_ok_next = 1'b0;
                end
            end else begin
                if (!q_item.is_digit) begin
                    tail_ok_next = 1'b0;
                end
                if ((pos == POS_TENTH) && !q_item.is_digit && !q_item.is_x) begin
                    tenth_ok_next = 1'b0;
                end
            end
        end

        if (q_pop && q_item.end_of_string) begin
            m_valid_next = 1'b1;
            if (char_count_next == COUNT_TEN) begin
                m_data_next.length_kind = LEN_TEN;
                m_data_next.valid_res   = nine_ok_next & tenth_ok_next &
                                          (sum11_next == 4'd0);
            end else if (char_count_next == COUNT_THIRTEEN) begin
                m_data_next.length_kind = LEN_THIRTEEN;
                m_data_next.valid_res   = nine_ok_next & tail_ok_next &
                                          (sum10_next == 4'd0);
            end else begin
                m_data_next.length_kind = LEN_OTHER;
                m_data_next.valid_res   = 1'b0;
            end
            // Ready for the next string
            char_count_next = 4'd0;
            sum11_next      = 4'd0;
            sum10_next      = 4'd0;
            nine_ok_next    = 1'b1;
            tenth_ok_next   = 1'b1;
            tail_ok_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg <= 4'd0;
            sum11_reg      <= 4'd0;
            sum10_reg      <= 4'd0;
            nine_ok_reg    <= 1'b1;
            tenth_ok_reg   <= 1'b1;
            tail_ok_reg    <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            char_count_reg <= char_count_next;
            sum11_reg      <= sum11_next;
            sum10_reg      <= sum10_next;
            nine_ok_reg    <= nine_ok_next;
            tenth_ok_reg   <= tenth_ok_next;
            tail_ok_reg    <= tail_ok_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Verdict payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        char_count_reg <= COUNT_SAT)
        else $error("character count past saturation");

    a_sums_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum11_reg <= 4'd10) && (sum10_reg <= 4'd9))
        else $error("running sum not reduced");

    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.end_of_string) |=> (char_count_reg == 4'd0) && m_valid_reg)
        else $error("state not cleared after end marker");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.end_of_string) |-> out_room)
        else $error("pending verdict overwritten");

endmodule

/* rtl/core/isbn_check_digit_validator_unit.sv */
// ----------------------------------------------------------------------------
// isbn_check_digit_validator_unit: ISBN-10 / ISBN-13 check-digit validator
// Streams ISBN characters in and gives one verdict per string.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per character (ch with has_char = 1); the
//   last transaction of a string carries end_of_string = 1, with or without
//   a character. An empty string is a lone end marker with has_char = 0.
//   m_ channel: one verdict transaction per end marker: valid_res and
//   length_kind (0 other, 1 ten, 2 thirteen characters).
//   Throughput: one transaction per cycle while verdicts are taken; the
//   accumulator updates its modulo-11 and modulo-10 sums combinationally.
//   Verdict path: the end marker is queued at acceptance and popped into
//   the verdict register once it heads the queue and that register has
//   room; the verdict is presented from the register.
//   Receiver stall: a pending verdict holds; characters keep flowing until
//   the next end marker reaches the accumulator, after which the queue
//   fills and s_ready drops.
//   Reset: synchronous on aresetn low; the queue empties, sums clear and
//   any pending verdict is dropped.
// ----------------------------------------------------------------------------
module isbn_check_digit_validator_unit import isbn_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  isbn_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output isbn_out_t m_data
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    isbn_item_t push_item;
    isbn_item_t pop_item;

    // Classifier
    isbn_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (push_item)
    );

    // Decoupling queue
    isbn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    // Accumulator and verdict
    isbn_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

/* test/isbn_check_digit_validator_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isbn_check_digit_validator_unit_test: self-checking bench for the validator
// Streams ISBN-10, ISBN-13 and malformed strings into the block, predicts
// each verdict from a behavioural model of the running sums and flags, and
// compares every verdict transaction against the oldest prediction. Both
// channels idle at random; the receiver also holds off once for a long run.
// ----------------------------------------------------------------------------
import isbn_pkg::*;

// Behavioural model of the accumulator plus the queue of predicted verdicts
class isbn_verdict_board;
    logic [3:0] char_count;
    logic [3:0] sum_eleven;
    logic [3:0] sum_ten;
    bit         nine_ok;
    bit         tenth_ok;
    bit         tail_ok;
    isbn_out_t  verdicts_due[$];
    int         mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        char_count = '0;
        sum_eleven = '0;
        sum_ten    = '0;
        nine_ok    = 1'b1;
        tenth_ok   = 1'b1;
        tail_ok    = 1'b1;
    endfunction

    function int pending();
        return verdicts_due.size();
    endfunction

    // Fold one accepted input transaction into the model
    function void note_item(isbn_in_t item);
        bit        digit;
        int        val;
        isbn_out_t verdict;
        digit = (item.ch >= ASCII_ZERO) && (item.ch <= ASCII_NINE);
        val   = digit ? int'(item.ch - ASCII_ZERO) : 0;
        if (item.has_char && (char_count < COUNT_SAT)) begin
            if (char_count < POS_TENTH) begin
                if (!digit)
                    nine_ok = 1'b0;
                sum_eleven = 4'((int'(sum_eleven) + val * (10 - int'(char_count))) % 11);
            end else begin
                // check character of ISBN-10: digit or upper-case X worth ten
                if (char_count == POS_TENTH) begin
                    if (digit)
                        sum_eleven = 4'((int'(sum_eleven) + val) % 11);
                    else if (item.ch == ASCII_UPPER_X)
                        sum_eleven = 4'((int'(sum_eleven) + 10) % 11);
                    else
                        tenth_ok = 1'b0;
                end
                if (!digit)
                    tail_ok = 1'b0;
            end
            sum_ten    = 4'((int'(sum_ten) + val * (char_count[0] ? 3 : 1)) % 10);
            char_count = char_count + 4'd1;
        end
        if (item.end_of_string) begin
            verdict.valid_res   = 1'b0;
            verdict.length_kind = LEN_OTHER;
            if (char_count == COUNT_TEN) begin
                verdict.length_kind = LEN_TEN;
                verdict.valid_res   = nine_ok && tenth_ok && (sum_eleven == 4'd0);
            end else if (char_count == COUNT_THIRTEEN) begin
                verdict.length_kind = LEN_THIRTEEN;
                verdict.valid_res   = nine_ok && tail_ok && (sum_ten == 4'd0);
            end
            verdicts_due.push_back(verdict);
            restart();
        end
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // Compare one accepted verdict transaction with the oldest prediction
    task check_verdict(isbn_out_t got);
        isbn_out_t want;
        if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("verdict valid_res=%0b length_kind=%0d with none due",
                                      got.valid_res, got.length_kind));
            return;
        end
        want = verdicts_due.pop_front();
        if (got.valid_res !== want.valid_res)
            report_mismatch($sformatf("valid_res %0b, predicted %0b",
                                      got.valid_res, want.valid_res));
        if (got.length_kind !== want.length_kind)
            report_mismatch($sformatf("length_kind %0d, predicted %0d",
                                      got.length_kind, want.length_kind));
    endtask
endclass

module isbn_check_digit_validator_unit_test;

    localparam int         HOLD_CYCLES = 80;
    localparam int         TAIL_CYCLES = 8;
    localparam logic [7:0] LOWER_X     = 8'h78;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    isbn_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    isbn_out_t m_data;

    isbn_verdict_board board = new();

    logic [7:0] text[$];
    int         items_sent      = 0;
    bit         calm            = 1'b0;
    bit         rx_hold_pending = 1'b0;
    int         rx_hold_left    = 0;
    int         rx_idle_left    = 0;

    isbn_check_digit_validator_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: check verdicts, then drive ready with bursts and the long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_verdict(m_data);
        if (rx_hold_pending) begin
            rx_hold_pending = 1'b0;
            rx_hold_left    = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_idle_left > 0) begin
            rx_idle_left--;
            m_ready <= 1'b0;
        end else if (!calm && ($urandom_range(0, 5) == 0)) begin
            rx_idle_left = $urandom_range(1, 5) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one transaction and hold it until accepted; valid stays high after
    task send_item(isbn_in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        do
            @(posedge aclk);
        while (!s_ready);
        board.note_item(item);
        if (item.has_char || item.end_of_string)
            items_sent++;
    endtask

    task tx_idle(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Random sender gap, none in the calm tail
    task maybe_gap(bit allow);
        if (allow && !calm && ($urandom_range(0, 6) == 0))
            tx_idle($urandom_range(1, 5));
    endtask

    // Send the current text; end marker on the last character or on its own
    task send_text(bit separate_end, bit gaps);
        isbn_in_t item;
        for (int i = 0; i < text.size(); i++) begin
            maybe_gap(gaps);
            if (gaps && ($urandom_range(0, 9) == 0)) begin
                item.ch            = 8'($urandom_range(0, 255));
                item.has_char      = 1'b0;
                item.end_of_string = 1'b0;
                send_item(item);
            end
            item.ch            = text[i];
            item.has_char      = 1'b1;
            item.end_of_string = !separate_end && (i == text.size() - 1);
            send_item(item);
        end
        if (separate_end || (text.size() == 0)) begin
            maybe_gap(gaps);
            item.ch            = 8'($urandom_range(0, 255));
            item.has_char      = 1'b0;
            item.end_of_string = 1'b1;
            send_item(item);
        end
    endtask

    task load_text(string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    function logic [7:0] rand_digit();
        return ASCII_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Damage a well-formed string: change one character or swap two neighbours
    task corrupt_text();
        int         p;
        logic [7:0] c;
        p = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 4))
            0: begin
                c = text[p];
                while (c == text[p])
                    c = rand_digit();
                text[p] = c;
            end
            1: text[p] = 8'($urandom_range(0, 255));
            2: text[p] = ASCII_UPPER_X;
            3: text[text.size() - 1] = LOWER_X;
            default: begin
                if (p == text.size() - 1)
                    p--;
                c           = text[p];
                text[p]     = text[p + 1];
                text[p + 1] = c;
            end
        endcase
    endtask

    task build_isbn10();
        int sum;
        int chk;
        text.delete();
        sum = 0;
        for (int i = 0; i < 9; i++) begin
            text.push_back(rand_digit());
            sum += int'(text[i] - ASCII_ZERO) * (10 - i);
        end
        chk = (11 - (sum % 11)) % 11;
        text.push_back((chk == 10) ? ASCII_UPPER_X : ASCII_ZERO + 8'(chk));
    endtask

    task build_isbn13();
        int sum;
        text.delete();
        sum = 0;
        for (int i = 0; i < 12; i++) begin
            text.push_back(rand_digit());
            sum += int'(text[i] - ASCII_ZERO) * ((i % 2 == 1) ? 3 : 1);
        end
        text.push_back(ASCII_ZERO + 8'((10 - (sum % 10)) % 10));
    endtask

    // Random length from 0 to max_len, mostly digits with X and raw bytes mixed in
    task build_noise(int max_len);
        int len;
        text.delete();
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    text.push_back(8'($urandom_range(0, 255)));
                2:       text.push_back(ASCII_UPPER_X);
                default: text.push_back(rand_digit());
            endcase
        end
    endtask

    // One random string, mostly well-formed ISBNs
    task send_random_string();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            build_isbn10();
        else if (pick < 70)
            build_isbn13();
        else if (pick < 80)
            build_noise(20);
        else begin
            build_noise(0);
            repeat ($urandom_range(9, 15))
                text.push_back(rand_digit());
        end
        if ((pick < 70) && ($urandom_range(0, 3) == 0))
            corrupt_text();
        send_text($urandom_range(0, 3) == 0, 1'b1);
    endtask

    task wait_for_verdicts();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Main sequence
    initial begin
        isbn_in_t item;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty string, ISBN-10 ending in X, ISBN-13 with lone end marker
        item.ch            = 8'hFF;
        item.has_char      = 1'b0;
        item.end_of_string = 1'b1;
        send_item(item);
        load_text("080442957X");
        send_text(1'b0, 1'b0);
        load_text("9780306406157");
        send_text(1'b1, 1'b0);

        while (items_sent < 420)
            send_random_string();

        // Long receiver hold-off while short strings keep coming
        rx_hold_pending = 1'b1;
        repeat (12) begin
            build_noise(3);
            send_text(1'b0, 1'b0);
        end
        wait_for_verdicts();

        while (items_sent < 480)
            send_random_string();

        // Calm tail: no idling on either side
        calm = 1'b1;
        while (items_sent < 600)
            send_random_string();

        wait_for_verdicts();
        if (board.mismatches == 0)
            $display("isbn_check_digit_validator_unit: match");
        else
            $display("isbn_check_digit_validator_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("isbn_check_digit_validator_unit: mismatch");
        $finish;
    end

endmodule
